// File: hdl/gcb_pkg.sv
// ----------------------------------------------------------------------------
// gcb_pkg
// Shared types and constants for the group commit batcher.
// ----------------------------------------------------------------------------
package gcb_pkg;

  localparam int MaxGroups = 16;
  localparam int SlotW = $clog2(MaxGroups);
  localparam int CountW = $clog2(MaxGroups + 1);

  localparam logic [2:0] CmdSubmit  = 3'd0;
  localparam logic [2:0] CmdPoll    = 3'd1;
  localparam logic [2:0] CmdSeal    = 3'd2;
  localparam logic [2:0] CmdStop    = 3'd3;
  localparam logic [2:0] CmdFinish  = 3'd4;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StInvalid   = 3'd1;
  localparam logic [2:0] StExhausted = 3'd2;
  localparam logic [2:0] StRange     = 3'd3;
  localparam logic [2:0] StFull      = 3'd4;
  localparam logic [2:0] StNoCapture = 3'd5;

  localparam logic [2:0] RegTargetMembers = 3'd0;
  localparam logic [2:0] RegMaxMembers    = 3'd1;
  localparam logic [2:0] RegTargetBytes   = 3'd2;
  localparam logic [2:0] RegMaxWait       = 3'd3;
  localparam logic [2:0] RegGroupSlots    = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_WAIT,
    S_SUBMIT,
    S_DONE
  } state_t;

endpackage

// File: hdl/group_commit_batcher.sv
// ----------------------------------------------------------------------------
// group_commit_batcher
// Coalesces log submissions into flush batches held in a group ring memory.
// ----------------------------------------------------------------------------
//  channel  | ports                                              | direction
//  command  | start, busy (out), cmd, member_count, submit_bytes, | in
//           | origin_time, now_time                              |
//  result   | done, status, sealed_now, wake, captured, capture_*,| out
//           | held_groups                                        |
//  config   | cfg_we, cfg_index, cfg_data                        | in
//
// every request walks the ring from the head, one entry read per cycle
// behind the registered memory read, up to the first sealed entry or the
// tail; after acceptance it passes the WALK, WAIT, SUBMIT and DONE states.
// busy is high from acceptance until done rises, so the next request can be
// taken at the edge that ends done.
// rst clears all control state; the ring memory is not cleared. done lasts
// one cycle; the receiver cannot stall.
module group_commit_batcher
  import gcb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [15:0] member_count,
  input  logic [31:0] submit_bytes,
  input  logic [47:0] origin_time,
  input  logic [47:0] now_time,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output logic        done,
  output logic [2:0]  status,
  output logic        sealed_now,
  output logic        wake,
  output logic        captured,
  output logic [4:0]  capture_groups,
  output logic [19:0] capture_members,
  output logic [35:0] capture_bytes,
  output logic [47:0] capture_deadline,
  output logic [4:0]  held_groups
);

  logic [15:0] seal_members;
  logic [15:0] max_members;
  logic [31:0] seal_bytes;
  logic [47:0] max_wait;
  logic [4:0]  group_slots;

  // ring memory: members, bytes, deadline
  logic [95:0] ring_mem [MaxGroups];
  logic [95:0] rd_data;
  logic        mem_we;
  logic [SlotW-1:0] mem_waddr;
  logic [95:0] mem_wdata;
  logic [SlotW-1:0] mem_raddr;

  logic [MaxGroups-1:0] sealed_bits;
  logic [SlotW-1:0]  ring_head;
  logic [CountW-1:0] ring_count;
  logic        forming_valid;
  logic [19:0] forming_member_sum;
  logic [35:0] forming_byte_sum;
  logic [47:0] forming_deadline_min;
  logic        active_valid;
  logic [CountW-1:0] active_groups;
  logic [19:0] active_member_sum;
  logic [35:0] active_byte_sum;
  logic [47:0] active_deadline;
  logic        stopped;

  state_t state, state_next;

  // latched request
  logic [2:0]  q_cmd;
  logic [15:0] q_members;
  logic [31:0] q_bytes;
  logic [47:0] q_origin;
  logic [47:0] q_now;

  // walk registers
  logic [CountW-1:0] walk_k;
  logic [CountW-1:0] walk_n;
  logic        walk_hit;
  logic        walk_first;
  logic [19:0] walk_m;
  logic [35:0] walk_b;
  logic [47:0] walk_d;
  logic [SlotW-1:0] walk_last;

  logic [2:0]  r_status;
  logic        r_sealed;
  logic        r_wake;

  logic [CountW-1:0] slots_eff;
  logic [48:0] deadline_full;
  logic [47:0] sub_deadline;
  logic [2:0]  sub_check;

  assign slots_eff = (group_slots > 5'(MaxGroups)) ? CountW'(MaxGroups)
                                                   : CountW'(group_slots);
  assign deadline_full = {1'b0, q_origin} + {1'b0, max_wait};
  assign sub_deadline = deadline_full[47:0];

  always_comb begin
    if (q_members == 16'd0 || q_origin > q_now) sub_check = StInvalid;
    else if (q_members > max_members) sub_check = StExhausted;
    else if (deadline_full[48]) sub_check = StRange;
    else if ({1'b0, ring_count} >= {1'b0, slots_eff}) sub_check = StFull;
    else sub_check = StOk;
  end

  // memory
  always_ff @(posedge clk) begin
    if (mem_we) ring_mem[mem_waddr] <= mem_wdata;
    rd_data <= ring_mem[mem_raddr];
  end

  assign mem_raddr = ring_head + walk_k[SlotW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      seal_members <= 16'd1;
      max_members <= 16'hFFFF;
      seal_bytes <= 32'd4096;
      max_wait <= 48'd0;
      group_slots <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        RegTargetMembers: seal_members <= cfg_data[15:0];
        RegMaxMembers:    max_members <= cfg_data[15:0];
        RegTargetBytes:   seal_bytes <= cfg_data[31:0];
        RegMaxWait:       max_wait <= cfg_data;
        RegGroupSlots:    group_slots <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  logic walk_end;
  assign walk_end = (walk_k >= ring_count);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_WALK;
      S_WALK: state_next = S_WAIT;
      S_WAIT: begin
        if (walk_hit || walk_end) state_next = S_SUBMIT;
      end
      S_SUBMIT: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != S_IDLE);
  end

  // per-cycle sealing helpers for submit
  logic        f_valid1;
  logic        seal1;
  logic [19:0] f_m1, f_m2;
  logic [35:0] f_b1, f_b2;
  logic [47:0] f_d1, f_d2;
  logic [CountW-1:0] tail_idx;
  logic [SlotW-1:0] tail_slot, new_slot;
  logic [CountW-1:0] cnt_new;
  logic        seal2;
  logic [MaxGroups-1:0] sealed_sub;

  always_comb begin
    tail_idx = ring_count - CountW'(1);
    tail_slot = ring_head + tail_idx[SlotW-1:0];
    new_slot = ring_head + ring_count[SlotW-1:0];
    cnt_new = ring_count + CountW'(1);
    sealed_sub = sealed_bits;
    seal1 = forming_valid &&
            ((forming_member_sum + 20'(q_members) > 20'(seal_members)) ||
             ({1'b0, forming_byte_sum} + 37'(q_bytes) > 37'(seal_bytes)) ||
             (max_wait != 48'd0 && q_now >= forming_deadline_min));
    f_valid1 = forming_valid;
    if (seal1) begin
      if (ring_count != '0) sealed_sub[tail_slot] = 1'b1;
      f_valid1 = 1'b0;
    end
    if (!f_valid1) begin
      f_m1 = '0;
      f_b1 = '0;
      f_d1 = sub_deadline;
    end else begin
      f_m1 = forming_member_sum;
      f_b1 = forming_byte_sum;
      f_d1 = forming_deadline_min;
    end
    f_m2 = f_m1 + 20'(q_members);
    f_b2 = f_b1 + 36'(q_bytes);
    f_d2 = (sub_deadline < f_d1) ? sub_deadline : f_d1;
    sealed_sub[new_slot] = 1'b0;
    seal2 = (f_m2 >= 20'(seal_members)) || (f_b2 >= 36'(seal_bytes)) ||
            (cnt_new >= slots_eff) || stopped;
    if (seal2) sealed_sub[new_slot] = 1'b1;
  end

  logic [SlotW-1:0] walk_slot;
  assign walk_slot = ring_head + walk_k[SlotW-1:0] - SlotW'(1);

  always_ff @(posedge clk) begin
    if (start && state == S_IDLE) begin
      q_cmd <= cmd;
      q_members <= member_count;
      q_bytes <= submit_bytes;
      q_origin <= origin_time;
      q_now <= now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sealed_bits <= '0;
      ring_head <= '0;
      ring_count <= '0;
      forming_valid <= 1'b0;
      forming_member_sum <= '0;
      forming_byte_sum <= '0;
      forming_deadline_min <= '0;
      active_valid <= 1'b0;
      active_groups <= '0;
      active_member_sum <= '0;
      active_byte_sum <= '0;
      active_deadline <= '0;
      stopped <= 1'b0;
      walk_k <= '0;
      walk_n <= '0;
      walk_hit <= 1'b0;
      walk_first <= 1'b0;
      walk_m <= '0;
      walk_b <= '0;
      walk_d <= '0;
      walk_last <= '0;
      r_status <= StOk;
      r_sealed <= 1'b0;
      r_wake <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          walk_k <= '0;
          walk_n <= '0;
          walk_hit <= 1'b0;
          walk_first <= 1'b1;
          walk_m <= '0;
          walk_b <= '0;
          walk_d <= '0;
        end
        S_WALK: begin
          walk_k <= walk_k + CountW'(1);
        end
        S_WAIT: begin
          if (!(walk_hit || walk_end)) begin
            walk_k <= walk_k + CountW'(1);
          end
          if (walk_k != '0 && !walk_hit && walk_n != ring_count) begin
            walk_n <= walk_n + CountW'(1);
            walk_last <= walk_slot;
            walk_m <= walk_m + 20'(rd_data[95:80]);
            walk_b <= walk_b + 36'(rd_data[79:48]);
            if (walk_first || rd_data[47:0] < walk_d) walk_d <= rd_data[47:0];
            walk_first <= 1'b0;
            if (sealed_bits[walk_slot]) walk_hit <= 1'b1;
          end
        end
        S_SUBMIT: begin
          r_status <= StOk;
          r_sealed <= 1'b0;
          r_wake <= 1'b0;
          case (q_cmd)
            CmdSubmit: begin
              if (sub_check != StOk) begin
                r_status <= sub_check;
              end else begin
                sealed_bits <= sealed_sub;
                ring_count <= cnt_new;
                forming_valid <= !seal2;
                forming_member_sum <= f_m2;
                forming_byte_sum <= f_b2;
                forming_deadline_min <= f_d2;
                r_sealed <= (seal1 && ring_count != '0) || seal2;
                r_wake <= (ring_count == '0) || (seal1 && ring_count != '0) ||
                          seal2 || (f_d2 < walk_d);
              end
            end
            CmdPoll: begin
              if (!active_valid && ring_count != '0 &&
                  (walk_hit || stopped || q_now >= walk_d)) begin
                if (!sealed_bits[walk_last]) begin
                  sealed_bits[walk_last] <= 1'b1;
                  r_sealed <= 1'b1;
                end
                if (forming_valid && walk_n == ring_count)
                  forming_valid <= 1'b0;
                active_valid <= 1'b1;
                active_groups <= walk_n;
                active_member_sum <= walk_m;
                active_byte_sum <= walk_b;
                active_deadline <= walk_d;
                r_wake <= 1'b1;
              end
            end
            CmdSeal, CmdStop: begin
              if (q_cmd == CmdStop) stopped <= 1'b1;
              if (forming_valid && ring_count != '0) begin
                sealed_bits[tail_slot] <= 1'b1;
                r_sealed <= 1'b1;
              end
              forming_valid <= 1'b0;
              r_wake <= 1'b1;
            end
            CmdFinish: begin
              if (!active_valid) begin
                r_status <= StNoCapture;
              end else begin
                for (int i = 0; i < MaxGroups; i++) begin
                  if (CountW'(SlotW'(i) - ring_head) < active_groups)
                    sealed_bits[i] <= 1'b0;
                end
                ring_head <= ring_head + active_groups[SlotW-1:0];
                ring_count <= ring_count - active_groups;
                if (ring_count == active_groups) forming_valid <= 1'b0;
                active_valid <= 1'b0;
                active_groups <= '0;
                active_member_sum <= '0;
                active_byte_sum <= '0;
                active_deadline <= '0;
                r_wake <= 1'b1;
              end
            end
            default: r_status <= StInvalid;
          endcase
        end
        S_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    mem_we = (state == S_SUBMIT) && (q_cmd == CmdSubmit) && (sub_check == StOk);
    mem_waddr = new_slot;
    mem_wdata = {q_members, q_bytes, sub_deadline};
  end

  assign status = r_status;
  assign sealed_now = r_sealed;
  assign wake = r_wake;
  assign captured = active_valid;
  assign capture_groups = active_valid ? 5'(active_groups) : 5'd0;
  assign capture_members = active_valid ? active_member_sum : 20'd0;
  assign capture_bytes = active_valid ? active_byte_sum : 36'd0;
  assign capture_deadline = active_valid ? active_deadline : 48'd0;
  assign held_groups = 5'(ring_count);

endmodule
